// ===== rtl/psg_register_dump_decompressor_macros.svh =====
// Assertion macros for the register-dump decompressor.
// Included by the RTL files that carry concurrent checks.
`ifndef PSG_REGISTER_DUMP_DECOMPRESSOR_MACROS_SVH
`define PSG_REGISTER_DUMP_DECOMPRESSOR_MACROS_SVH

`ifndef ASSERT_OFF
`define PSG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PSG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSG_ASSERT(lbl, clk, rst_n, prop, msg)
`define PSG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/psg_rdd_pkg.sv =====
// Shared constants, types and helper functions of the register-dump decompressor.
// No dependencies; used by the channel interfaces, the top-level module and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package psg_rdd_pkg;

    localparam int ROWS        = 128;
    localparam int REGS        = 14;
    localparam int ROW_W       = $clog2(ROWS);
    localparam int REG_W       = $clog2(REGS);
    localparam int VAL_W       = 8;
    localparam int STORE_DEPTH = REGS * 2 * ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int FRAG_W      = 10;
    localparam int CNT_W       = 16;
    localparam int FR_W        = FRAG_W + ROW_W;
    localparam int FIELD_BITS  = 7;
    localparam int COPY_W      = FIELD_BITS + 1;
    localparam int BITS_W      = 4;
    localparam int LOW_REGS    = 7;
    localparam int LOW_W       = 41;
    localparam int HIGH_W      = 47;

    typedef enum logic [2:0] {
        PH_FLAG,
        PH_CODE,
        PH_KIND,
        PH_RAW,
        PH_OFFSET,
        PH_COUNT
    } t_phase;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BIT,
        ST_FILL,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_ROW_RD,
        ST_ROW_CAP,
        ST_FINISH
    } t_state;

    function automatic logic [BITS_W-1:0] f_reg_width(input logic [REG_W-1:0] idx);
        logic [BITS_W-1:0] w;
        case (idx)
            4'd1, 4'd3, 4'd5:       w = 4'd4;
            4'd6, 4'd8, 4'd9, 4'd10: w = 4'd5;
            default:                 w = 4'd8;
        endcase
        return w;
    endfunction

    function automatic logic [VAL_W-1:0] f_mask(input logic [BITS_W-1:0] w);
        logic [VAL_W:0] m;
        m = (9'd1 << w) - 9'd1;
        return m[VAL_W-1:0];
    endfunction

    // Bit offset of a register inside its packed half (low: 0..6, high: 7..13).
    function automatic int f_pack_off(input int idx);
        int off;
        int base;
        off  = 0;
        base = (idx < LOW_REGS) ? 0 : LOW_REGS;
        for (int k = 0; k < LOW_REGS; k++) begin
            if (base + k < idx) begin
                off = off + int'(f_reg_width(REG_W'(base + k)));
            end
        end
        return off;
    endfunction

    function automatic logic [ADDR_W-1:0] f_store_addr(input logic [REG_W-1:0] idx,
                                                      input logic slot,
                                                      input logic [ROW_W-1:0] row);
        int a;
        a = (int'(idx) * 2 + int'(slot)) * ROWS + int'(row);
        return ADDR_W'(a);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/psg_rdd_ifs.sv =====
// Valid/ready channel interfaces of the register-dump decompressor:
// request input, result output and row-count configuration. Uses psg_rdd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface psg_rdd_in_if
    import psg_rdd_pkg::*;
;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] stream_byte;

    modport source (output valid, op, stream_byte, input ready);
    modport sink   (input valid, op, stream_byte, output ready);
endinterface

interface psg_rdd_out_if
    import psg_rdd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              row_valid;
    logic [LOW_W-1:0]  regs_low_packed;
    logic [HIGH_W-1:0] regs_high_packed;
    logic [CNT_W-1:0]  row_number;
    logic              last_row;
    logic [CNT_W-1:0]  rows_decoded;
    logic              decode_done;
    logic              overrun;

    modport source (output valid, row_valid, regs_low_packed, regs_high_packed, row_number,
                    last_row, rows_decoded, decode_done, overrun, input ready);
    modport sink   (input valid, row_valid, regs_low_packed, regs_high_packed, row_number,
                    last_row, rows_decoded, decode_done, overrun, output ready);
endinterface

interface psg_rdd_cfg_if
    import psg_rdd_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] row_count;

    modport source (output valid, row_count, input ready);
    modport sink   (input valid, row_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/psg_rdd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module psg_rdd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/psg_register_dump_decompressor.sv =====
// Top level of the register-dump stream decompressor: bit decoder, fragment store, row reader.
// Depends on psg_rdd_pkg, psg_rdd_ifs, psg_rdd_ram and the assertion macro header.
//
//  Channel   | Port      | Direction | Carries
//  ----------+-----------+-----------+-------------------------------------------
//  request   | i_in_ch   | sink      | op, stream_byte
//  result    | o_out_ch  | source    | row_valid, packed rows, row_number, status
//  config    | i_cfg_ch  | sink      | row_count (always ready)
//
// After reset a clearing pass writes zero to all 3584 store entries with the request
// channel held not ready. A pushed byte is decoded bit by bit; each unchanged-fragment
// flag writes all 128 rows of the fragment and each copied value is read and then
// written through the single store write port. A row read fetches each register in turn.
// The result register lets the next request be taken while a result waits.
`timescale 1ns / 1ps
`default_nettype none
`include "psg_register_dump_decompressor_macros.svh"

module psg_register_dump_decompressor
    import psg_rdd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    psg_rdd_in_if.sink   i_in_ch,
    psg_rdd_out_if.source o_out_ch,
    psg_rdd_cfg_if.sink  i_cfg_ch
);

    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic [VAL_W-1:0]    r_acc, n_acc;
    logic [BITS_W-1:0]   r_bits, n_bits;
    logic [REG_W-1:0]    r_reg, n_reg;
    logic [ROW_W-1:0]    r_elem, n_elem;
    logic [FRAG_W-1:0]   r_frag, n_frag;
    logic [FIELD_BITS-1:0] r_off, n_off;
    logic [CNT_W-1:0]    r_read_row, n_read_row;
    logic                r_overrun, n_overrun;
    logic [CNT_W-1:0]    r_row_count, n_row_count;
    logic [VAL_W-1:0]    r_last_val [REGS];
    logic [VAL_W-1:0]    n_last_val [REGS];
    logic [VAL_W-1:0]    r_byte, n_byte;
    logic [2:0]          r_bitpos, n_bitpos;
    logic [COPY_W-1:0]   r_copy_left, n_copy_left;
    logic [ADDR_W-1:0]   r_clr, n_clr;
    logic [REG_W-1:0]    r_rdreg, n_rdreg;
    logic                r_hit, n_hit;
    logic [VAL_W-1:0]    r_vals [REGS];
    logic                r_ov, n_ov;

    logic                r_o_row_valid;
    logic [LOW_W-1:0]    r_o_low;
    logic [HIGH_W-1:0]   r_o_high;
    logic [CNT_W-1:0]    r_o_row_num;
    logic                r_o_last;
    logic [CNT_W-1:0]    r_o_rows;
    logic                r_o_done;
    logic                r_o_overrun;

    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    logic [VAL_W-1:0]    w_wdata;
    logic [ADDR_W-1:0]   w_raddr;
    logic [VAL_W-1:0]    w_rdata;

    logic                w_in_acc;
    logic                w_out_free;
    logic                w_load_out;
    logic                w_bit;
    logic [BITS_W-1:0]   w_width;
    logic [VAL_W-1:0]    w_last;
    logic [FR_W-1:0]     w_fr;
    logic                w_done;
    logic [CNT_W-1:0]    w_rows_ready;
    logic                w_ovr;
    logic                w_read_ok;
    logic                w_elem_end;
    logic                w_raw_done;
    logic                w_field_done;
    logic [VAL_W-1:0]    w_acc_raw;
    logic [FIELD_BITS-1:0] w_acc_fld;
    logic [ROW_W+1:0]    w_src;
    logic                w_src_hi;
    logic [ROW_W-1:0]    w_src_row;
    logic [LOW_W-1:0]    w_pack_low;
    logic [HIGH_W-1:0]   w_pack_high;
    t_state              w_nb_state;

    psg_rdd_ram #(
        .WIDTH (VAL_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign i_in_ch.ready  = (r_state == ST_IDLE);
    assign i_cfg_ch.ready = 1'b1;
    assign w_in_acc       = i_in_ch.valid && i_in_ch.ready;
    assign w_out_free     = !r_ov || o_out_ch.ready;
    assign w_load_out     = (r_state == ST_FINISH) && w_out_free;

    assign w_bit   = r_byte[r_bitpos];
    assign w_width = f_reg_width(r_reg);
    assign w_last  = r_last_val[r_reg];

    assign w_fr         = FR_W'(r_frag) * FR_W'(ROWS);
    assign w_done       = w_fr >= FR_W'(r_row_count);
    assign w_rows_ready = w_done ? r_row_count : w_fr[CNT_W-1:0];
    assign w_read_ok    = r_read_row < w_rows_ready;
    // Overwriting fragment f while rows of fragment f-2 are still unread.
    assign w_ovr = (r_frag >= FRAG_W'(2)) &&
                   (FR_W'(r_read_row) < FR_W'(r_frag - FRAG_W'(1)) * FR_W'(ROWS));

    assign w_elem_end   = (r_elem == ROW_W'(ROWS - 1));
    assign w_acc_raw    = {r_acc[VAL_W-2:0], w_bit};
    assign w_acc_fld    = {r_acc[FIELD_BITS-2:0], w_bit};
    assign w_raw_done   = (r_bits + BITS_W'(1)) >= w_width;
    assign w_field_done = (r_bits + BITS_W'(1)) >= BITS_W'(FIELD_BITS);

    // Copy source: offset plus destination row, spanning the previous and current slots.
    assign w_src     = (ROW_W+2)'(r_off) + (ROW_W+2)'(r_elem);
    assign w_src_hi  = w_src >= (ROW_W+2)'(ROWS);
    assign w_src_row = w_src_hi ? ROW_W'(w_src - (ROW_W+2)'(ROWS)) : w_src[ROW_W-1:0];

    assign w_nb_state = (r_bitpos == 3'd0) ? ST_FINISH : ST_BIT;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == ADDR_W'(STORE_DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (!i_in_ch.op)    n_state = ST_BIT;
                    else if (w_read_ok) n_state = ST_ROW_RD;
                    else                n_state = ST_FINISH;
                end
            end
            ST_BIT: begin
                if (w_done) begin
                    n_state = ST_FINISH;
                end else begin
                    case (r_phase)
                        PH_FLAG:  n_state = w_bit ? w_nb_state : ST_FILL;
                        PH_COUNT: n_state = w_field_done ? ST_COPY_RD : w_nb_state;
                        default:  n_state = w_nb_state;
                    endcase
                end
            end
            ST_FILL: begin
                if (w_elem_end) n_state = w_nb_state;
            end
            ST_COPY_RD: n_state = ST_COPY_WR;
            ST_COPY_WR: begin
                if (w_elem_end || r_copy_left == COPY_W'(1)) n_state = w_nb_state;
                else                                         n_state = ST_COPY_RD;
            end
            ST_ROW_RD: n_state = ST_ROW_CAP;
            ST_ROW_CAP: begin
                if (r_rdreg == REG_W'(REGS - 1)) n_state = ST_FINISH;
                else                             n_state = ST_ROW_RD;
            end
            ST_FINISH: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and store access.
    always_comb begin
        logic             do_adv;
        logic             do_end;
        logic             do_wr;
        logic [ROW_W-1:0] wr_row;
        logic [VAL_W-1:0] wr_val;

        n_phase     = r_phase;
        n_acc       = r_acc;
        n_bits      = r_bits;
        n_reg       = r_reg;
        n_elem      = r_elem;
        n_frag      = r_frag;
        n_off       = r_off;
        n_read_row  = r_read_row;
        n_overrun   = r_overrun;
        n_row_count = r_row_count;
        n_last_val  = r_last_val;
        n_byte      = r_byte;
        n_bitpos    = r_bitpos;
        n_copy_left = r_copy_left;
        n_clr       = r_clr;
        n_rdreg     = r_rdreg;
        n_hit       = r_hit;
        n_ov        = r_ov;
        w_we        = 1'b0;
        w_waddr     = r_clr;
        w_wdata     = '0;
        w_raddr     = '0;
        do_adv      = 1'b0;
        do_end      = 1'b0;
        do_wr       = 1'b0;
        wr_row      = r_elem;
        wr_val      = w_last;

        if (i_cfg_ch.valid) begin
            n_row_count = i_cfg_ch.row_count;
        end
        if (r_ov && o_out_ch.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                w_we  = 1'b1;
                n_clr = r_clr + ADDR_W'(1);
            end
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_byte   = i_in_ch.stream_byte;
                    n_bitpos = 3'd7;
                    n_hit    = 1'b0;
                    n_rdreg  = '0;
                end
            end
            ST_BIT: begin
                if (!w_done) begin
                    n_bitpos = r_bitpos - 3'd1;
                    case (r_phase)
                        PH_FLAG: begin
                            n_elem = '0;
                            if (w_bit) n_phase = PH_CODE;
                        end
                        PH_CODE: begin
                            if (!w_bit) begin
                                do_wr  = 1'b1;
                                do_adv = 1'b1;
                            end else begin
                                n_phase = PH_KIND;
                            end
                        end
                        PH_KIND: begin
                            n_acc   = '0;
                            n_bits  = '0;
                            n_phase = w_bit ? PH_RAW : PH_OFFSET;
                        end
                        PH_RAW: begin
                            n_acc  = w_acc_raw;
                            n_bits = r_bits + BITS_W'(1);
                            if (w_raw_done) begin
                                do_wr   = 1'b1;
                                wr_val  = w_acc_raw;
                                n_phase = PH_CODE;
                                do_adv  = 1'b1;
                            end
                        end
                        PH_OFFSET: begin
                            n_acc  = VAL_W'(w_acc_fld);
                            n_bits = r_bits + BITS_W'(1);
                            if (w_field_done) begin
                                n_off   = w_acc_fld;
                                n_acc   = '0;
                                n_bits  = '0;
                                n_phase = PH_COUNT;
                            end
                        end
                        PH_COUNT: begin
                            n_acc  = VAL_W'(w_acc_fld);
                            n_bits = r_bits + BITS_W'(1);
                            if (w_field_done) begin
                                n_copy_left = COPY_W'(w_acc_fld) + COPY_W'(1);
                                n_phase     = PH_CODE;
                                // The bit position moves on once the copy is over.
                                n_bitpos    = r_bitpos;
                            end
                        end
                        default: n_phase = PH_FLAG;
                    endcase
                    if (r_phase == PH_FLAG && !w_bit) begin
                        n_bitpos = r_bitpos;
                    end
                end
            end
            ST_FILL: begin
                do_wr = 1'b1;
                if (w_elem_end) begin
                    do_end   = 1'b1;
                    n_bitpos = r_bitpos - 3'd1;
                end else begin
                    n_elem = r_elem + ROW_W'(1);
                end
            end
            ST_COPY_RD: begin
                w_raddr = f_store_addr(r_reg, ~r_frag[0] ^ w_src_hi, w_src_row);
            end
            ST_COPY_WR: begin
                do_wr       = 1'b1;
                wr_val      = w_rdata;
                do_adv      = 1'b1;
                n_copy_left = r_copy_left - COPY_W'(1);
                if (w_elem_end || r_copy_left == COPY_W'(1)) begin
                    n_bitpos = r_bitpos - 3'd1;
                end
            end
            ST_ROW_RD: begin
                w_raddr = f_store_addr(r_rdreg, r_read_row[ROW_W], r_read_row[ROW_W-1:0]);
            end
            ST_ROW_CAP: begin
                n_rdreg = r_rdreg + REG_W'(1);
                if (r_rdreg == REG_W'(REGS - 1)) begin
                    n_hit = 1'b1;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_ov = 1'b1;
                    if (r_hit) n_read_row = r_read_row + CNT_W'(1);
                end
            end
            default: ;
        endcase

        if (do_wr) begin
            w_we    = 1'b1;
            w_waddr = f_store_addr(r_reg, r_frag[0], wr_row);
            w_wdata = wr_val & f_mask(w_width);
            n_last_val[r_reg] = wr_val & f_mask(w_width);
            if (w_ovr) n_overrun = 1'b1;
        end
        if (do_adv) begin
            if (w_elem_end) do_end = 1'b1;
            else            n_elem = r_elem + ROW_W'(1);
        end
        if (do_end) begin
            n_elem  = '0;
            n_phase = PH_FLAG;
            if (r_reg == REG_W'(REGS - 1)) begin
                n_reg  = '0;
                n_frag = r_frag + FRAG_W'(1);
            end else begin
                n_reg = r_reg + REG_W'(1);
            end
        end
    end

    always_comb begin
        w_pack_low  = '0;
        w_pack_high = '0;
        for (int i = 0; i < LOW_REGS; i++) begin
            w_pack_low = w_pack_low | (LOW_W'(r_vals[i]) << f_pack_off(i));
        end
        for (int i = LOW_REGS; i < REGS; i++) begin
            w_pack_high = w_pack_high | (HIGH_W'(r_vals[i]) << f_pack_off(i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_phase     <= PH_FLAG;
            r_acc       <= '0;
            r_bits      <= '0;
            r_reg       <= '0;
            r_elem      <= '0;
            r_frag      <= '0;
            r_off       <= '0;
            r_read_row  <= '0;
            r_overrun   <= 1'b0;
            r_row_count <= '0;
            r_last_val  <= '{default: '0};
            r_bitpos    <= '0;
            r_copy_left <= '0;
            r_clr       <= '0;
            r_rdreg     <= '0;
            r_hit       <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_bits      <= n_bits;
            r_reg       <= n_reg;
            r_elem      <= n_elem;
            r_frag      <= n_frag;
            r_off       <= n_off;
            r_read_row  <= n_read_row;
            r_overrun   <= n_overrun;
            r_row_count <= n_row_count;
            r_last_val  <= n_last_val;
            r_bitpos    <= n_bitpos;
            r_copy_left <= n_copy_left;
            r_clr       <= n_clr;
            r_rdreg     <= n_rdreg;
            r_hit       <= n_hit;
            r_ov        <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        if (r_state == ST_ROW_CAP) begin
            r_vals[r_rdreg] <= w_rdata;
        end
        if (w_load_out) begin
            r_o_row_valid <= r_hit;
            r_o_low       <= r_hit ? w_pack_low : '0;
            r_o_high      <= r_hit ? w_pack_high : '0;
            r_o_row_num   <= r_hit ? r_read_row : '0;
            r_o_last      <= r_hit &&
                             ((FR_W'(r_read_row) + FR_W'(1)) == FR_W'(r_row_count));
            r_o_rows      <= w_rows_ready;
            r_o_done      <= w_done;
            r_o_overrun   <= r_overrun;
        end
    end

    assign o_out_ch.valid            = r_ov;
    assign o_out_ch.row_valid        = r_o_row_valid;
    assign o_out_ch.regs_low_packed  = r_o_low;
    assign o_out_ch.regs_high_packed = r_o_high;
    assign o_out_ch.row_number       = r_o_row_num;
    assign o_out_ch.last_row         = r_o_last;
    assign o_out_ch.rows_decoded     = r_o_rows;
    assign o_out_ch.decode_done      = r_o_done;
    assign o_out_ch.overrun          = r_o_overrun;

    `PSG_ASSERT(a_no_store_write_idle, i_clk, i_rst_n,
        (r_state == ST_IDLE) |-> !w_we, "store written while idle")
    `PSG_ASSERT(a_overrun_sticky, i_clk, i_rst_n,
        r_overrun |=> r_overrun, "overrun flag cleared")
    `PSG_ASSERT(a_frag_wraps_reg, i_clk, i_rst_n,
        !$stable(r_frag) |-> (r_reg == '0), "fragment advanced without register wrap")
    `PSG_ASSERT(a_copy_from_rd, i_clk, i_rst_n,
        (r_state == ST_COPY_WR) |-> ($past(r_state) == ST_COPY_RD), "copy write without read")

endmodule

`default_nettype wire

// ===== tb/psg_rdd_tb_ifs.sv =====
// Testbench-side helpers for the decompressor channels.
// Depends on psg_rdd_pkg; the channel interfaces themselves come from rtl/psg_rdd_ifs.sv.
`timescale 1ns / 1ps

package psg_rdd_tb_pkg;
    import psg_rdd_pkg::*;

    typedef struct packed {
        logic              row_valid;
        logic [LOW_W-1:0]  regs_low_packed;
        logic [HIGH_W-1:0] regs_high_packed;
        logic [CNT_W-1:0]  row_number;
        logic              last_row;
        logic [CNT_W-1:0]  rows_decoded;
        logic              decode_done;
        logic              overrun;
    } t_row_result;
endpackage

// ===== tb/tb.sv =====
// Self-checking testbench of the register-dump decompressor: pushes compressed bytes,
// reads rows and compares each result with a built-in decoder. Depends on the RTL files.
`timescale 1ns / 1ps

class dump_decoder;
    localparam int ROWS = 128;
    localparam int REGS = 14;
    localparam int PH_FLAG = 0, PH_CODE = 1, PH_KIND = 2, PH_RAW = 3, PH_OFFSET = 4,
                   PH_COUNT = 5;
    localparam int OP_PUSH = 0, OP_READ = 1;

    bit [7:0]  store_mem [REGS*2*ROWS];
    bit [7:0]  last_val [REGS];
    int        phase, acc, nbits, reg_idx, elem, frag, offs, rd_row;
    bit        ovr;
    int        row_count;
    int        errors;
    psg_rdd_tb_pkg::t_row_result pending[$];

    function new();
        foreach (store_mem[i]) store_mem[i] = 0;
        foreach (last_val[i]) last_val[i] = 0;
        phase = PH_FLAG; acc = 0; nbits = 0; reg_idx = 0; elem = 0; frag = 0; offs = 0;
        rd_row = 0; ovr = 0; row_count = 0; errors = 0;
    endfunction

    function int width_of(int r);
        case (r)
            1, 3, 5: return 4;
            6, 8, 9, 10: return 5;
            default: return 8;
        endcase
    endfunction

    function int addr(int r, int slot, int row);
        return ((r % REGS) * 2 + (slot & 1)) * ROWS + (row % ROWS);
    endfunction

    function bit done();
        return frag * ROWS >= row_count;
    endfunction

    function int ready_rows();
        return (frag * ROWS < row_count) ? frag * ROWS : row_count;
    endfunction

    function void put(int row, int v);
        v = v & ((1 << width_of(reg_idx)) - 1);
        if (frag >= 2 && rd_row < (frag - 1) * ROWS) ovr = 1;
        store_mem[addr(reg_idx, frag, row)] = v;
        last_val[reg_idx] = v;
    endfunction

    function void close_fragment();
        elem = 0;
        phase = PH_FLAG;
        reg_idx++;
        if (reg_idx >= REGS) begin
            reg_idx = 0;
            frag++;
        end
    endfunction

    function void step_row();
        elem++;
        if (elem >= ROWS) close_fragment();
    endfunction

    function void take_bit(int b);
        int n, src, v;
        case (phase)
            PH_FLAG: begin
                if (b == 0) begin
                    for (int r = 0; r < ROWS; r++) put(r, last_val[reg_idx]);
                    close_fragment();
                end else begin
                    elem = 0;
                    phase = PH_CODE;
                end
            end
            PH_CODE: begin
                if (b == 0) begin
                    put(elem, last_val[reg_idx]);
                    step_row();
                end else begin
                    phase = PH_KIND;
                end
            end
            PH_KIND: begin
                acc = 0; nbits = 0;
                phase = b ? PH_RAW : PH_OFFSET;
            end
            PH_RAW: begin
                acc = ((acc << 1) | b) & 8'hFF;
                nbits++;
                if (nbits >= width_of(reg_idx)) begin
                    put(elem, acc);
                    phase = PH_CODE;
                    step_row();
                end
            end
            PH_OFFSET: begin
                acc = ((acc << 1) | b) & 7'h7F;
                nbits++;
                if (nbits >= 7) begin
                    offs = acc; acc = 0; nbits = 0;
                    phase = PH_COUNT;
                end
            end
            default: begin
                acc = ((acc << 1) | b) & 7'h7F;
                nbits++;
                if (nbits >= 7) begin
                    n = acc + 1;
                    phase = PH_CODE;
                    for (int k = 0; k < n && phase == PH_CODE; k++) begin
                        src = offs + elem;
                        v = store_mem[addr(reg_idx, frag + 1 + src / ROWS, src % ROWS)];
                        put(elem, v);
                        step_row();
                    end
                end
            end
        endcase
    endfunction

    // Notes one accepted request and queues the result it must produce.
    function void note_request(bit op, bit [7:0] data);
        psg_rdd_tb_pkg::t_row_result res;
        int slot, row, sh;
        res = '0;
        if (op == OP_PUSH) begin
            for (int i = 7; i >= 0; i--) begin
                if (done()) break;
                take_bit(data[i]);
            end
        end else if (rd_row < ready_rows()) begin
            slot = rd_row / ROWS;
            row = rd_row % ROWS;
            sh = 0;
            for (int i = 0; i < 7; i++) begin
                res.regs_low_packed |= 41'(store_mem[addr(i, slot, row)]) << sh;
                sh += width_of(i);
            end
            sh = 0;
            for (int i = 7; i < REGS; i++) begin
                res.regs_high_packed |= 47'(store_mem[addr(i, slot, row)]) << sh;
                sh += width_of(i);
            end
            res.row_valid = 1;
            res.row_number = rd_row[15:0];
            res.last_row = (rd_row + 1 == row_count);
            rd_row++;
        end
        res.rows_decoded = ready_rows();
        res.decode_done = done();
        res.overrun = ovr;
        pending.push_back(res);
    endfunction

    function void check_result(psg_rdd_tb_pkg::t_row_result got);
        psg_rdd_tb_pkg::t_row_result exp;
        if (pending.size() == 0) begin
            $error("unexpected result with nothing pending");
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (got.row_valid !== exp.row_valid) begin
            $error("row_valid exp %0h got %0h", exp.row_valid, got.row_valid); errors++;
        end
        if (got.regs_low_packed !== exp.regs_low_packed) begin
            $error("regs_low_packed exp %0h got %0h", exp.regs_low_packed,
                   got.regs_low_packed); errors++;
        end
        if (got.regs_high_packed !== exp.regs_high_packed) begin
            $error("regs_high_packed exp %0h got %0h", exp.regs_high_packed,
                   got.regs_high_packed); errors++;
        end
        if (got.row_number !== exp.row_number) begin
            $error("row_number exp %0h got %0h", exp.row_number, got.row_number); errors++;
        end
        if (got.last_row !== exp.last_row) begin
            $error("last_row exp %0h got %0h", exp.last_row, got.last_row); errors++;
        end
        if (got.rows_decoded !== exp.rows_decoded) begin
            $error("rows_decoded exp %0h got %0h", exp.rows_decoded, got.rows_decoded);
            errors++;
        end
        if (got.decode_done !== exp.decode_done) begin
            $error("decode_done exp %0h got %0h", exp.decode_done, got.decode_done); errors++;
        end
        if (got.overrun !== exp.overrun) begin
            $error("overrun exp %0h got %0h", exp.overrun, got.overrun); errors++;
        end
    endfunction
endclass

module tb;
    import psg_rdd_pkg::*;

    localparam bit OP_PUSH = 1'b0;
    localparam bit OP_READ = 1'b1;
    localparam longint CYCLE_LIMIT = 3_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    longint cycles = 0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;

    psg_rdd_in_if  in_ch ();
    psg_rdd_out_if out_ch ();
    psg_rdd_cfg_if cfg_ch ();

    dump_decoder decoder = new();

    psg_register_dump_decompressor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in_ch (in_ch),
        .o_out_ch(out_ch),
        .i_cfg_ch(cfg_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.op = 1'b0;
        in_ch.stream_byte = 8'h00;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.row_count = '0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver side: stall at random, check every accepted result.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            decoder.check_result({out_ch.row_valid, out_ch.regs_low_packed,
                                  out_ch.regs_high_packed, out_ch.row_number,
                                  out_ch.last_row, out_ch.rows_decoded,
                                  out_ch.decode_done, out_ch.overrun});
        end
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Valid stays high after an accepted request so that the next one can follow
    // at once; idle cycles and wait_drained take it low.
    task automatic send_request(bit op, bit [7:0] data);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.stream_byte <= data;
        do @(posedge i_clk); while (!in_ch.ready);
        decoder.note_request(op, data);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (decoder.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_row_count(int value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.row_count <= value[15:0];
        do @(posedge i_clk); while (!cfg_ch.ready);
        decoder.row_count = value & 16'hFFFF;
        cfg_ch.valid <= 1'b0;
    endtask

    // Emits bits MSB first into whole bytes.
    bit bit_buf[$];

    task automatic flush_bits();
        bit [7:0] b;
        while (bit_buf.size() != 0) begin
            for (int i = 7; i >= 0; i--) b[i] = (bit_buf.size() != 0) ? bit_buf.pop_front()
                                                                  : 1'($urandom_range(1));
            send_request(OP_PUSH, b);
            if ($urandom_range(3) == 0) send_request(OP_READ, 8'($urandom));
        end
    endtask

    function automatic void add_bits(int value, int n);
        for (int i = n - 1; i >= 0; i--) bit_buf.push_back(value[i]);
    endfunction

    // A well-formed register fragment with random codes.
    function automatic void add_fragment(int r, bit wide_copies);
        int row, n, w;
        w = decoder.width_of(r);
        if ($urandom_range(4) == 0) begin
            add_bits(0, 1);
            return;
        end
        add_bits(1, 1);
        row = 0;
        while (row < 128) begin
            case ($urandom_range(2))
                0: begin add_bits(0, 1); row++; end
                1: begin add_bits(3, 2); add_bits($urandom, w); row++; end
                default: begin
                    n = wide_copies ? $urandom_range(127) : $urandom_range(15);
                    add_bits(2, 2);
                    add_bits($urandom_range(127), 7);
                    add_bits(n, 7);
                    row += n + 1;
                end
            endcase
        end
    endfunction

    task automatic run_stream(int frags, int rows, bit read_all);
        write_row_count(rows);
        for (int f = 0; f < frags; f++) begin
            for (int r = 0; r < 14; r++) begin
                add_fragment(r, $urandom_range(1));
                if (bit_buf.size() >= 64) flush_bits();
            end
        end
        flush_bits();
        // Three stray bytes follow the stream; they are ignored once decoding is complete.
        repeat (3) send_request(OP_PUSH, 8'($urandom));
        if (read_all) begin
            repeat (rows + 2) send_request(OP_READ, 8'($urandom));
        end
    endtask

    initial begin
        int n_items;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes of byte and op before any row count, then a tiny stream.
        send_request(OP_READ, 8'h00);
        send_request(OP_PUSH, 8'hFF);
        send_request(OP_PUSH, 8'h00);
        send_request(OP_READ, 8'hFF);
        wait_drained();
        write_row_count(1);
        send_request(OP_PUSH, 8'hFF);
        send_request(OP_PUSH, 8'hFF);
        send_request(OP_PUSH, 8'h55);
        send_request(OP_PUSH, 8'hAA);
        send_request(OP_PUSH, 8'h80);
        repeat (4) send_request(OP_READ, 8'h00);
        wait_drained();

        src_idle_pct = 9;
        snk_idle_pct = 82;
        run_stream(1, 100, 1'b1);
        wait_drained();

        src_idle_pct = 82;
        snk_idle_pct = 9;
        // Row count raised mid-stream with rows left unread; each zero bit is an unchanged-fragment
        // flag, so the zero bytes repeat fragments until unread rows are overwritten.
        write_row_count(65535);
        repeat (64) send_request(OP_PUSH, 8'h00);
        wait_drained();
        run_stream(1, 65535, 1'b0);
        repeat (40) send_request(OP_READ, 8'h00);
        wait_drained();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        n_items = 0;
        while (n_items < 40) begin
            if ($urandom_range(9) == 0) send_request(OP_PUSH, 8'($urandom));
            else send_request(OP_READ, 8'($urandom));
            n_items++;
        end
        wait_drained();
        write_row_count(0);
        send_request(OP_READ, 8'h00);
        send_request(OP_PUSH, 8'h00);

        wait_drained();
        if (decoder.errors == 0 && decoder.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/psg_rdd_pkg.sv
rtl/psg_rdd_ifs.sv
rtl/psg_rdd_ram.sv
rtl/psg_register_dump_decompressor.sv
tb/psg_rdd_tb_ifs.sv
tb/tb.sv
